// ===== hdl/wmahp_pkg.sv =====
// shared types and widths for the windowed moving-average high-pass filter
// no dependencies; used by wmahp_resq and windowed_moving_average_highpass
`default_nettype none

package wmahp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 7;
  // exact result width: 4*x - sum of four samples
  localparam int EXACT_W  = 19;
  // result queue depth and its pointer and count widths
  localparam int QUEUE_D  = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [EXACT_W-1:0]  exact_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic [POS_W-1:0]           position;
    logic                       last;
    logic                       wrapped;
  } res_t;

  // push request into the result queue: zero, one or two results
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

`default_nettype wire

// ===== hdl/windowed_moving_average_highpass.sv =====
// each result is written into the result queue on the beat that causes it and offered from the queue head
// throughput: one sample per cycle while in_stall is low; the beat after a full window gives two results
// in_stall rises while the four-entry result queue holds more than two results
// reset (rst_n low, synchronous) clears the delay line, window count and queue
// depends on wmahp_pkg and wmahp_resq
`default_nettype none

module windowed_moving_average_highpass #(
  parameter int WINDOW_LENGTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_filtered,
  output logic [6:0]       out_position,
  output logic             out_last,
  output logic             out_wrapped
);

  localparam int CW = $clog2(WINDOW_LENGTH + 1);
  localparam int PW = wmahp_pkg::POS_W;
  localparam int EW = wmahp_pkg::EXACT_W;
  localparam int LastPos = WINDOW_LENGTH - 1;
  localparam int PrevPos = WINDOW_LENGTH - 2;

  // delay line, oldest first, and window count
  wmahp_pkg::sample_t a_r, b_r, c_r;
  wmahp_pkg::sample_t a_nxt, b_nxt, c_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  logic                in_acc;
  logic                flush;
  logic                full;
  wmahp_pkg::exact_t   ae, be, ce, se;
  wmahp_pkg::exact_t   e0, e1;
  logic [CW-1:0]       pm2;
  wmahp_pkg::push_t    push;
  wmahp_pkg::res_t     head;
  logic                head_valid;

  assign in_acc = in_valid && !in_stall;
  assign full   = (count_r >= CW'(WINDOW_LENGTH));
  assign flush  = in_acc && full;

  // sign-extend to the exact width; the dropped sample counts as zero
  assign ae = {{(EW-16){a_r[15]}}, a_r};
  assign be = {{(EW-16){b_r[15]}}, b_r};
  assign ce = {{(EW-16){c_r[15]}}, c_r};
  assign se = full ? '0 : {{(EW-16){in_sample[15]}}, in_sample};

  // high-pass results: centred one and, on flush, the final one
  assign e0  = (be <<< 2) - (ae + be + ce + se);
  assign e1  = (ce <<< 2) - (be + ce);
  assign pm2 = count_r - CW'(2);

  always_comb begin
    push.first.filtered  = e0[15:0];
    push.first.position  = full ? PW'(PrevPos) : PW'(pm2);
    push.first.last      = 1'b0;
    push.first.wrapped   = !((e0[EW-1:15] == '0) || (e0[EW-1:15] == '1));
    push.second.filtered = e1[15:0];
    push.second.position = PW'(LastPos);
    push.second.last     = 1'b1;
    push.second.wrapped  = !((e1[EW-1:15] == '0) || (e1[EW-1:15] == '1));
    if (!in_acc) begin
      push.num = 2'd0;
    end else if (full) begin
      push.num = 2'd2;
    end else if (count_r >= CW'(2)) begin
      push.num = 2'd1;
    end else begin
      push.num = 2'd0;
    end
  end

  // delay line and count update
  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    count_nxt = count_r;
    if (flush) begin
      a_nxt     = '0;
      b_nxt     = '0;
      c_nxt     = '0;
      count_nxt = '0;
    end else if (in_acc) begin
      a_nxt     = b_r;
      b_nxt     = c_r;
      c_nxt     = in_sample;
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r     <= '0;
      b_r     <= '0;
      c_r     <= '0;
      count_r <= '0;
    end else begin
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      c_r     <= c_nxt;
      count_r <= count_nxt;
    end
  end

  // result queue parts input from output side
  wmahp_resq u_resq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (!out_stall),
    .nearly_full (in_stall)
  );

  assign out_valid    = head_valid;
  assign out_filtered = head.filtered;
  assign out_position = head.position;
  assign out_last     = head.last;
  assign out_wrapped  = head.wrapped;

  // window count never passes the window length
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WINDOW_LENGTH))
    else $error("window count out of range");

  // a flush beat restarts the window with a cleared delay line
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    flush |=> (count_r == '0) && (a_r == '0) && (b_r == '0) && (c_r == '0))
    else $error("window not restarted after flush");

  // the final result of a window sits at the last position
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_position == PW'(LastPos)))
    else $error("last flag on wrong position");

  // a result is offered on the cycle after a flush beat
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    flush |=> out_valid)
    else $error("flush results not queued");

endmodule

`default_nettype wire

// ===== hdl/wmahp_resq.sv =====
// small result queue, takes up to two results per cycle, gives one per beat
// depends on wmahp_pkg (res_t, push_t, queue sizes)
`default_nettype none

module wmahp_resq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire wmahp_pkg::push_t push,
  output wmahp_pkg::res_t      head,
  output logic                 head_valid,
  input  wire logic            pop,
  output logic                 nearly_full
);

  localparam int PW = wmahp_pkg::QPTR_W;
  localparam int CW = wmahp_pkg::QCNT_W;

  wmahp_pkg::res_t q_r [wmahp_pkg::QUEUE_D];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign head        = q_r[rd_r];
  assign head_valid  = (cnt_r != '0);
  // room for two more results is needed before a new beat may come in
  assign nearly_full = (cnt_r > CW'(wmahp_pkg::QUEUE_D - 2));
  assign do_pop      = pop && head_valid;

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r + PW'(push.num);
    rd_nxt  = do_pop ? rd_r + PW'(1) : rd_r;
    cnt_nxt = cnt_r + CW'(push.num) - (do_pop ? CW'(1) : CW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      q_r[wr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      q_r[wr_r + PW'(1)] <= push.second;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_windowed_moving_average_highpass.sv =====
// testbench for windowed_moving_average_highpass: drives sample beats, tracks expected results
// depends on wmahp_pkg and the filter rtl; self-checking, prints pass or fail at the end
`timescale 1ns / 1ps

module tb_windowed_moving_average_highpass;

  localparam int WIN      = 128;
  localparam int SHOW_MAX = 10;

  // expected-result tracker: own copy of the delay line and window fill
  class highpass_tracker;
    wmahp_pkg::sample_t hist[3];
    int unsigned        fill;
    wmahp_pkg::res_t    due[$];
    int                 errors;

    function new();
      clear_window();
      errors = 0;
    endfunction

    function void clear_window();
      hist[0] = '0;
      hist[1] = '0;
      hist[2] = '0;
      fill = 0;
    endfunction

    // wrap the exact value to 16 bits and queue it
    function void push_due(int ex, int unsigned pos, bit fin);
      wmahp_pkg::res_t r;
      r.filtered = ex[15:0];
      r.position = pos[6:0];
      r.last     = fin;
      r.wrapped  = (ex < -32768) || (ex > 32767);
      due.push_back(r);
    endfunction

    // one accepted input beat
    function void take_sample(wmahp_pkg::sample_t s);
      int a, b, c, x;
      a = int'(hist[0]);
      b = int'(hist[1]);
      c = int'(hist[2]);
      x = int'(s);
      if (fill >= WIN) begin
        // beat after a full window: sample dropped, last two positions flushed
        push_due(4 * b - (a + b + c), WIN - 2, 1'b0);
        push_due(4 * c - (b + c), WIN - 1, 1'b1);
        clear_window();
      end else begin
        if (fill >= 2)
          push_due(4 * b - (a + b + c + x), fill - 2, 1'b0);
        hist[0] = hist[1];
        hist[1] = hist[2];
        hist[2] = s;
        fill++;
      end
    endfunction

    // one accepted output beat against the oldest expectation
    function void match_result(wmahp_pkg::res_t got);
      wmahp_pkg::res_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("error: unexpected result filtered=%0d position=%0d last=%0b wrapped=%0b",
                   got.filtered, got.position, got.last, got.wrapped);
        return;
      end
      want = due.pop_front();
      if (got.filtered !== want.filtered || got.position !== want.position ||
          got.last !== want.last || got.wrapped !== want.wrapped) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("error: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b (filtered/pos/last/wrap)",
                   want.filtered, want.position, want.last, want.wrapped,
                   got.filtered, got.position, got.last, got.wrapped);
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [15:0] in_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_filtered;
  logic [6:0]  out_position;
  logic        out_last;
  logic        out_wrapped;
  logic        quiet     = 1'b0;

  highpass_tracker tracker = new();

  windowed_moving_average_highpass #(
    .WINDOW_LENGTH(WIN)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .out_position (out_position),
    .out_last     (out_last),
    .out_wrapped  (out_wrapped)
  );

  always #5 clk = ~clk;

  // send one sample beat, with a random gap unless in a quiet stretch
  task automatic send_sample(input wmahp_pkg::sample_t s);
    if (!quiet) begin
      while ($urandom_range(99) < 23) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid  = 1'b1;
    in_sample = s;
    do @(posedge clk); while (in_stall);
    tracker.take_sample(s);
    @(negedge clk);
  endtask

  // random stall on the result side
  always @(negedge clk) begin
    out_stall = rst_n && !quiet && ($urandom_range(99) < 23);
  end

  // check accepted result beats
  always @(posedge clk) begin
    wmahp_pkg::res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.filtered = out_filtered;
      got.position = out_position;
      got.last     = out_last;
      got.wrapped  = out_wrapped;
      tracker.match_result(got);
    end
  end

  // stimulus
  initial begin
    wmahp_pkg::sample_t edge_set[20];
    wmahp_pkg::sample_t s;
    int                 pick;
    edge_set = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                 16'sh8000, 16'sh8000, 16'sh8000, 16'shFFFF, 16'sh0001,
                 16'sh5555, 16'shAAAA, 16'sh0000, 16'sh8000, 16'sh7FFF};

    // synchronous reset, released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes and overflow patterns at a window start
    foreach (edge_set[i])
      send_sample(edge_set[i]);

    // random: full range, extremes and small values; runs over many windows
    for (int n = 0; n < 1300; n++) begin
      quiet = (n >= 450) && (n < 750);
      pick = $urandom_range(9);
      if (pick < 5)
        s = wmahp_pkg::sample_t'($urandom);
      else if (pick < 7)
        case ($urandom_range(3))
          0: s = 16'sh7FFF;
          1: s = 16'sh8000;
          2: s = 16'shFFFF;
          default: s = 16'sh0000;
        endcase
      else
        s = wmahp_pkg::sample_t'($urandom_range(512) - 256);
      send_sample(s);
    end
    in_valid = 1'b0;
    quiet    = 1'b0;

    // drain outstanding results, then wait on for any strays
    for (int w = 0; w < 5000 && tracker.due.size() != 0; w++)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.due.size() != 0) begin
      tracker.errors++;
      $display("error: %0d expected results never arrived", tracker.due.size());
    end

    if (tracker.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
